### sv/pavf_pkg.sv
`default_nettype none
package pavf_pkg;

  localparam int MAX_SLOTS           = 4;
  localparam int ATTRIBUTES_DEFAULT  = 4;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 53;

  localparam logic [CFG_INDEX_W-1:0] REG_TOPOLOGY    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_COUNT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_MASK = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ATTR0       = 3'd3;

  localparam logic [1:0] TOPO_LINE     = 2'd1;
  localparam logic [1:0] TOPO_TRIANGLE = 2'd2;

  localparam logic [1:0] LINE_VERTS     = 2'd2;
  localparam logic [1:0] TRIANGLE_VERTS = 2'd3;

  localparam logic CMD_INDEX   = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam logic [2:0] MAX_COMPONENTS = 3'd4;

  typedef struct packed {
    logic        command;
    logic [15:0] vertex_index;
  } pavf_in_t;

  typedef struct packed {
    logic        request_valid;
    logic [1:0]  attribute_slot;
    logic [31:0] fetch_address;
    logic [2:0]  component_count;
    logic        component_type;
    logic        default_w_one;
    logic [1:0]  vertex_slot;
    logic        primitive_end;
    logic        last;
  } pavf_out_t;

  typedef struct packed {
    logic        position;
    logic        ctype;
    logic [2:0]  count;
    logic [15:0] stride;
    logic [31:0] base;
  } pavf_layout_t;

  typedef struct packed {
    logic [15:0] vertex_index;
    logic [1:0]  vertex_slot;
    logic        primitive_end;
  } pavf_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pavf_queue_status_t;

endpackage
`default_nettype wire

### sv/pavf_front.sv
`default_nettype none
module pavf_front
  import pavf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pavf_in_t           in_data,
  input  wire logic [1:0]         topology,
  input  wire logic [23:0]        index_count,
  input  wire pavf_queue_status_t q_status,
  output logic                    push,
  output pavf_job_t               push_job
);

  logic [23:0] read_count, read_count_next;
  logic [1:0]  slot_counter, slot_counter_next;
  logic [1:0]  nv;
  logic        accept, fits, pend;

  always_comb begin
    case (topology)
      TOPO_LINE:     nv = LINE_VERTS;
      TOPO_TRIANGLE: nv = TRIANGLE_VERTS;
      default:       nv = 2'd0;
    endcase
  end

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // a new primitive starts only if all its vertices fit in the draw
  assign fits = (slot_counter != 2'd0) ||
                (({1'b0, read_count} + 25'(nv)) <= {1'b0, index_count});
  assign pend = ({1'b0, slot_counter} + 3'd1) >= {1'b0, nv};

  assign push = accept && (in_data.command == CMD_INDEX) && (nv != 2'd0) && fits;

  assign push_job.vertex_index  = in_data.vertex_index;
  assign push_job.vertex_slot   = slot_counter;
  assign push_job.primitive_end = pend;

  always_comb begin
    read_count_next   = read_count;
    slot_counter_next = slot_counter;
    if (accept && in_data.command == CMD_RESTART) begin
      read_count_next   = '0;
      slot_counter_next = '0;
    end else if (push) begin
      read_count_next   = read_count + 24'd1;
      slot_counter_next = pend ? 2'd0 : slot_counter + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_count   <= '0;
      slot_counter <= '0;
    end else begin
      read_count   <= read_count_next;
      slot_counter <= slot_counter_next;
    end
  end

endmodule
`default_nettype wire

### sv/pavf_queue.sv
`default_nettype none
module pavf_queue
  import pavf_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire pavf_job_t    push_job,
  input  wire logic         pop,
  output pavf_job_t         head,
  output pavf_queue_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  pavf_job_t         entries [DEPTH];
  logic [AW-1:0]     wr_ptr, rd_ptr;
  logic [CW-1:0]     count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/pavf_back.sv
`default_nettype none
module pavf_back
  import pavf_pkg::*;
#(
  parameter int NUM_SLOTS = MAX_SLOTS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [3:0]                    enable_mask,
  input  wire pavf_layout_t [NUM_SLOTS-1:0]  layouts,
  input  wire pavf_queue_status_t            q_status,
  input  wire pavf_job_t                     head,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output pavf_out_t                          out_data
);

  pavf_job_t              cur;
  logic                   cur_valid;
  logic [NUM_SLOTS-1:0]   rem, rem_clr;
  logic [1:0]             sel;
  pavf_layout_t           lay;
  logic                   adv, finishing;
  logic [31:0]            product;
  pavf_out_t              result;

  // pick the lowest pending slot
  always_comb begin
    sel = '0;
    lay = '0;
    for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
      if (rem[j]) begin
        sel = 2'(j);
        lay = layouts[j];
      end
    end
    for (int j = 0; j < NUM_SLOTS; j++) begin
      rem_clr[j] = rem[j] && (2'(j) != sel);
    end
  end

  assign product = 32'(lay.stride) * 32'(cur.vertex_index);

  always_comb begin
    result               = '0;
    result.vertex_slot   = cur.vertex_slot;
    result.primitive_end = cur.primitive_end;
    if (rem == '0) begin
      // vertex without any enabled attribute: one marker beat
      result.last = 1'b1;
    end else begin
      result.request_valid   = 1'b1;
      result.attribute_slot  = sel;
      result.fetch_address   = lay.base + product;
      result.component_count = (lay.count > MAX_COMPONENTS) ? 3'd0 : lay.count;
      result.component_type  = lay.ctype;
      result.default_w_one   = lay.position;
      result.last            = (rem_clr == '0);
    end
  end

  assign adv       = !out_valid || out_ready;
  assign finishing = cur_valid && adv && (rem_clr == '0);
  // load the next vertex in the cycle its predecessor emits its last beat
  assign pop       = !q_status.empty && (!cur_valid || finishing);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        rem       <= enable_mask[NUM_SLOTS-1:0];
      end else begin
        if (finishing) begin
          cur_valid <= 1'b0;
        end
        if (cur_valid && adv) begin
          rem <= rem_clr;
        end
      end
      if (adv) begin
        out_valid <= cur_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (cur_valid && adv) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire

### sv/primitive_assembly_vertex_fetch.sv
`default_nettype none
// Groups a stream of 16-bit vertex indices into line or triangle primitives
// and issues one fetch request per enabled attribute slot for every vertex
// of a primitive that fits in the programmed index count (a marker beat
// when no slot is enabled). The front end takes one input beat per cycle
// while the vertex queue is not full; restart and dropped beats produce
// nothing. The back end emits one result beat per cycle unless out_ready
// stalls it, and its per-slot multiply-add stage sets the sustained rate.
// A QUEUE_DEPTH-entry (default two) vertex queue sits between the two; a
// vertex then passes the current-vertex and output registers before its
// first result. Program the registers only while the block is idle.
module primitive_assembly_vertex_fetch
  import pavf_pkg::*;
#(
  parameter int ATTRIBUTES  = ATTRIBUTES_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire pavf_in_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output pavf_out_t                   out_data,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int NUM_SLOTS = (ATTRIBUTES < MAX_SLOTS) ? ATTRIBUTES : MAX_SLOTS;

  logic [1:0]                    topology;
  logic [23:0]                   index_count;
  logic [3:0]                    enable_mask;
  pavf_layout_t [NUM_SLOTS-1:0]  layouts;

  pavf_queue_status_t q_status;
  pavf_job_t          push_job, head;
  logic               push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      topology    <= '0;
      index_count <= '0;
      enable_mask <= '0;
      layouts     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOPOLOGY:    topology    <= cfg_data[1:0];
        REG_INDEX_COUNT: index_count <= cfg_data[23:0];
        REG_ENABLE_MASK: enable_mask <= cfg_data[3:0];
        default: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (int'(cfg_index) == int'(REG_ATTR0) + i) begin
              layouts[i] <= cfg_data;
            end
          end
        end
      endcase
    end
  end

  pavf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .topology    (topology),
    .index_count (index_count),
    .q_status    (q_status),
    .push        (push),
    .push_job    (push_job)
  );

  pavf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  pavf_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .enable_mask (enable_mask),
    .layouts     (layouts),
    .q_status    (q_status),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.request_valid |-> out_data.last)
    else $error("marker beat without last");

  a_marker_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.request_valid |->
      out_data.fetch_address == 32'd0 && out_data.component_count == 3'd0)
    else $error("marker beat carries request fields");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("vertex queue popped while empty");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire
